@@ sv/pixel_compositing_unit_top_defines.svh @@
// assertion helpers for the checker file pcu_checker.sv
`ifndef PIXEL_COMPOSITING_UNIT_TOP_DEFINES_SVH
`define PIXEL_COMPOSITING_UNIT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PCU_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define PCU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pcu_pkg.sv @@
package pcu_pkg;

    localparam int NUM_LANES = 4;
    localparam int CH_W      = 8;
    localparam int FACTOR_W  = 17;
    localparam int MAG_W     = 24;
    localparam int PIX_W     = NUM_LANES * CH_W;

    localparam logic [2:0] MODE_COPY  = 3'd0;
    localparam logic [2:0] MODE_KEY   = 3'd1;
    localparam logic [2:0] MODE_TEST  = 3'd2;
    localparam logic [2:0] MODE_BLEND = 3'd3;
    localparam logic [2:0] MODE_CONST = 3'd4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_KEY    = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_SCALE  = 2'd3;

    localparam logic [8:0] SCALE_ONE  = 9'd256;

    typedef logic [CH_W-1:0] chan_t;

    // per-pixel operation resolved from the mode and the tests
    typedef enum logic [1:0]
    {
        OP_KEEP  = 2'd0,
        OP_PASS  = 2'd1,
        OP_BLEND = 2'd2,
        OP_CONST = 2'd3
    } op_t;

    typedef struct packed
    {
        logic en_b;
        logic en_c;
    } lane_ctl_t;

endpackage

@@ sv/pcu_lane.sv @@
module pcu_lane
(
    input  logic                          clk,
    input  pcu_pkg::chan_t                src,
    input  pcu_pkg::chan_t                dst,
    input  logic [pcu_pkg::FACTOR_W-1:0]  factor,
    input  pcu_pkg::op_t                  op_b,
    input  pcu_pkg::lane_ctl_t            ctl,
    output pcu_pkg::chan_t                color
);
    import pcu_pkg::*;

    logic             neg;
    chan_t            diff_mag;
    logic [MAG_W-1:0] mag_next;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    chan_t            src_reg;
    chan_t            dst_reg;
    logic [15:0]      coarse;
    logic [15:0]      rnd;
    chan_t            quot;
    chan_t            color_next;
    chan_t            color_reg;

    assign neg      = (src < dst);
    assign diff_mag = neg ? (dst - src) : (src - dst);
    assign mag_next = MAG_W'(diff_mag) * MAG_W'(factor);

    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg;
            src_reg <= src;
            dst_reg <= dst;
        end
    end

    // divide by 65280: drop 8 bits, then divide by 255 as (a + 1 + a/256) / 256
    assign coarse = mag_reg[MAG_W-1:8];
    assign rnd    = coarse + 16'd1 + {8'd0, coarse[15:8]};

    always_comb
    begin
        unique case (op_b)
            OP_BLEND: quot = rnd[15:8];
            OP_CONST: quot = mag_reg[15:8];
            default:  quot = '0;
        endcase
    end

    always_comb
    begin
        unique case (op_b)
            OP_KEEP:  color_next = dst_reg;
            OP_PASS:  color_next = src_reg;
            OP_BLEND,
            OP_CONST: color_next = neg_reg ? (dst_reg - quot) : (dst_reg + quot);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_c)
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

@@ sv/pcu_merge.sv @@
module pcu_merge
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcu_pkg::chan_t              lane_color [pcu_pkg::NUM_LANES],
    input  logic                        we,
    input  logic                        valid,
    output logic                        ready,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [pcu_pkg::PIX_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tuser
);
    import pcu_pkg::*;

    logic [PIX_W-1:0] data_next;
    logic [PIX_W-1:0] data_reg;
    logic             we_reg;
    logic             valid_reg;

    assign ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        for (int c = 0; c < NUM_LANES; c++)
        begin
            data_next[c*CH_W +: CH_W] = lane_color[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            data_reg <= data_next;
            we_reg   <= we;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = we_reg;

endmodule

@@ sv/pixel_compositing_unit_top.sv @@
// pixel compositing stage of a blitter
//
// input stream s_axis: one transfer carries a source pixel and the destination
// pixel under it, RGBA, 8 bits per channel. output stream m_axis: one transfer
// per input, the colour to write in tdata and the write enable in tuser.
// cfg port: mode, key colour, alpha threshold and alpha scale, written while
// the stream is idle. mode selects copy, colour key, alpha test, alpha blend
// or constant alpha.
//
// path: a pixel in the input register passes the multiply stage, the divide and
// select stage and the output register to m_axis. throughput: one pixel per
// clock unless m_axis stalls; the four channels run in parallel lanes.
// back-pressure: each stage moves on when the stage after it is empty or
// moving, so input is still taken while a result waits, until all four
// stages are full.
// reset: pipeline empties, mode is copy, key and threshold are zero and the
// scale is 256 (full weight).
module pixel_compositing_unit_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [2*pcu_pkg::PIX_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [pcu_pkg::PIX_W-1:0]   m_axis_tdata,
    // write_enable
    output logic                        m_axis_tuser,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);
    import pcu_pkg::*;

    logic [2:0]          mode_reg;
    logic [PIX_W-1:0]    key_reg;
    chan_t               thresh_reg;
    logic [8:0]          scale_reg;

    logic [8:0]          scale_eff;
    chan_t               src_alpha;
    op_t                 op_next;
    logic [FACTOR_W-1:0] factor_next;

    chan_t               src_a_reg [NUM_LANES];
    chan_t               dst_a_reg [NUM_LANES];
    logic [FACTOR_W-1:0] factor_a_reg;
    op_t                 op_a_reg;
    op_t                 op_b_reg;
    op_t                 op_c_reg;
    logic                valid_a_reg;
    logic                valid_b_reg;
    logic                valid_c_reg;

    logic                en_a;
    logic                en_b;
    logic                en_c;
    logic                merge_ready;
    lane_ctl_t           lane_ctl;
    chan_t               lane_color [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_COPY;
            key_reg    <= '0;
            thresh_reg <= '0;
            scale_reg  <= SCALE_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                REG_KEY:    key_reg    <= cfg_data[PIX_W-1:0];
                REG_THRESH: thresh_reg <= cfg_data[CH_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_data[8:0];
            endcase
        end
    end

    // scales above one act as one
    assign scale_eff = scale_reg[8] ? SCALE_ONE : scale_reg;
    assign src_alpha = s_axis_tdata[3*CH_W +: CH_W];

    always_comb
    begin
        op_next     = OP_KEEP;
        factor_next = '0;
        unique case (mode_reg)
            MODE_COPY:
                op_next = OP_PASS;
            MODE_KEY:
                op_next = (s_axis_tdata[PIX_W-1:0] != key_reg) ? OP_PASS : OP_KEEP;
            MODE_TEST:
                op_next = (src_alpha > thresh_reg) ? OP_PASS : OP_KEEP;
            MODE_BLEND:
            begin
                op_next     = OP_BLEND;
                factor_next = FACTOR_W'(src_alpha) * FACTOR_W'(scale_eff);
            end
            MODE_CONST:
            begin
                op_next     = OP_CONST;
                factor_next = FACTOR_W'(scale_eff);
            end
            default:
                op_next = OP_KEEP;
        endcase
    end

    // stage enables: a stage loads when it is empty or its content moves on
    assign en_c          = !valid_c_reg || merge_ready;
    assign en_b          = !valid_b_reg || en_c;
    assign en_a          = !valid_a_reg || en_b;
    assign s_axis_tready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                valid_a_reg <= s_axis_tvalid;
            end
            if (en_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (en_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            for (int c = 0; c < NUM_LANES; c++)
            begin
                src_a_reg[c] <= s_axis_tdata[c*CH_W +: CH_W];
                dst_a_reg[c] <= s_axis_tdata[PIX_W + c*CH_W +: CH_W];
            end
            factor_a_reg <= factor_next;
            op_a_reg     <= op_next;
        end
        if (en_b)
        begin
            op_b_reg <= op_a_reg;
        end
        if (en_c)
        begin
            op_c_reg <= op_b_reg;
        end
    end

    assign lane_ctl.en_b = en_b;
    assign lane_ctl.en_c = en_c;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        pcu_lane u_lane
        (
            .clk    (clk),
            .src    (src_a_reg[g]),
            .dst    (dst_a_reg[g]),
            .factor (factor_a_reg),
            .op_b   (op_b_reg),
            .ctl    (lane_ctl),
            .color  (lane_color[g])
        );
    end

    pcu_merge u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_color    (lane_color),
        .we            (op_c_reg != OP_KEEP),
        .valid         (valid_c_reg),
        .ready         (merge_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ sv/pcu_checker.sv @@
`include "pixel_compositing_unit_top_defines.svh"

module pcu_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [pcu_pkg::PIX_W-1:0]   m_axis_tdata,
    input logic                        m_axis_tuser
);
    import pcu_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    assign count_next = count_reg + {2'd0, in_xfer} - {2'd0, out_xfer};

    // pixels inside the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `PCU_CHECK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `PCU_CHECK(a_no_phantom, m_axis_tvalid, count_reg != 3'd0, "result with no pixel inside")
    `PCU_CHECK(a_depth, 1'b1, count_reg <= 3'd4, "more than four pixels inside")
    `PCU_CHECK(a_ready_room, count_reg < 3'd4, s_axis_tready, "input stalled with room inside")

endmodule

bind pixel_compositing_unit_top pcu_checker u_pcu_checker (.*);

@@ sim/tb_pixel_compositing_unit_top.sv @@
`timescale 1ns / 100ps

module tb_pixel_compositing_unit_top;

    import pcu_pkg::*;

    localparam int BLEND_DIV    = 255 * 256;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [2:0] MODE_TOP = 3'd7;

    // red in the low byte, so the struct maps straight onto tdata
    typedef struct packed
    {
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgba_t;

    typedef struct packed
    {
        logic  wr_en;
        rgba_t color;
    } comp_result_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    logic [2*PIX_W-1:0]   s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha
    logic [PIX_W-1:0]     m_axis_tdata;
    // write_enable
    logic                 m_axis_tuser;
    logic                 cfg_we        = 1'b0;
    logic [1:0]           cfg_index     = '0;
    logic [31:0]          cfg_data      = '0;

    // shadow copy of the configuration registers
    logic [2:0]           shadow_mode   = MODE_COPY;
    logic [31:0]          shadow_key    = '0;
    logic [7:0]           shadow_thresh = '0;
    logic [8:0]           shadow_scale  = SCALE_ONE;

    comp_result_t         pending_pixels[$];
    int                   mismatch_count = 0;
    int                   stall_cycles   = 0;
    int                   src_idle_pct   = 0;
    int                   sink_idle_pct  = 0;

    pixel_compositing_unit_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // dst + (src - dst) * num / den, truncated toward zero
    function automatic chan_t lerp_channel(chan_t s, chan_t d, int num, int den);
        int diff;
        int step;
        diff = int'(s) - int'(d);
        step = (diff * num) / den;
        return chan_t'(int'(d) + step);
    endfunction

    function automatic rgba_t lerp_pixel(rgba_t src, rgba_t dst, int num, int den);
        rgba_t mixed;
        mixed.red   = lerp_channel(src.red,   dst.red,   num, den);
        mixed.green = lerp_channel(src.green, dst.green, num, den);
        mixed.blue  = lerp_channel(src.blue,  dst.blue,  num, den);
        mixed.alpha = lerp_channel(src.alpha, dst.alpha, num, den);
        return mixed;
    endfunction

    function automatic comp_result_t composite_pixel(rgba_t src, rgba_t dst);
        comp_result_t res;
        int           eff_scale;
        res.wr_en = 1'b0;
        res.color = dst;
        // scale values past full weight saturate
        eff_scale = (shadow_scale > SCALE_ONE) ? int'(SCALE_ONE) : int'(shadow_scale);
        case (shadow_mode)
            MODE_COPY:
            begin
                res.wr_en = 1'b1;
                res.color = src;
            end
            MODE_KEY:
                if (src != shadow_key)
                begin
                    res.wr_en = 1'b1;
                    res.color = src;
                end
            MODE_TEST:
                if (src.alpha > shadow_thresh)
                begin
                    res.wr_en = 1'b1;
                    res.color = src;
                end
            MODE_BLEND:
            begin
                res.wr_en = 1'b1;
                res.color = lerp_pixel(src, dst, int'(src.alpha) * eff_scale, BLEND_DIV);
            end
            MODE_CONST:
            begin
                res.wr_en = 1'b1;
                res.color = lerp_pixel(src, dst, eff_scale, int'(SCALE_ONE));
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic rgba_t px(chan_t r, chan_t g, chan_t b, chan_t a);
        return {a, b, g, r};
    endfunction

    function automatic chan_t rand_channel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic rgba_t rand_pixel();
        return px(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endfunction

    // called at a falling edge, returns at a falling edge; tvalid stays high between
    // back-to-back transfers
    task automatic send_pixel(input rgba_t src, input rgba_t dst);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_pixels.push_back(composite_pixel(src, dst));
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // registers change only with the pipeline empty
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_MODE:   shadow_mode   = value[2:0];
            REG_KEY:    shadow_key    = value;
            REG_THRESH: shadow_thresh = value[7:0];
            REG_SCALE:  shadow_scale  = value[8:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        comp_result_t want;
        rgba_t        got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none, actual we=%0b color=%08h",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("write_enable", int'(want.wr_en), int'(m_axis_tuser));
                check_field("out_red",   int'(want.color.red),   int'(got.red));
                check_field("out_green", int'(want.color.green), int'(got.green));
                check_field("out_blue",  int'(want.color.blue),  int'(got.blue));
                check_field("out_alpha", int'(want.color.alpha), int'(got.alpha));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_pixels.size());
            $display("** pixel_compositing_unit_top: FAILED **");
            $finish;
        end
    end

    // runs on reset values: copy mode
    task automatic test_copy();
        send_pixel(px(8'hff, 8'hff, 8'hff, 8'hff), px(8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00), px(8'hff, 8'hff, 8'hff, 8'hff));
    endtask

    task automatic test_color_key();
        drain_pipeline();
        write_reg(REG_MODE, 32'(MODE_KEY));
        write_reg(REG_KEY, 32'h8040_2010);
        send_pixel(px(8'h10, 8'h20, 8'h40, 8'h80), px(8'haa, 8'h55, 8'h0f, 8'hf0));
        send_pixel(px(8'h11, 8'h20, 8'h40, 8'h80), px(8'haa, 8'h55, 8'h0f, 8'hf0));
        send_pixel(px(8'h10, 8'h20, 8'h40, 8'h00), px(8'h01, 8'h02, 8'h03, 8'h04));
        write_reg(REG_KEY, 32'hffff_ffff);
        send_pixel(px(8'hff, 8'hff, 8'hff, 8'hff), px(8'h12, 8'h34, 8'h56, 8'h78));
        send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00), px(8'h12, 8'h34, 8'h56, 8'h78));
    endtask

    task automatic test_alpha_test();
        drain_pipeline();
        write_reg(REG_MODE, 32'(MODE_TEST));
        // threshold still at its reset value of zero
        send_pixel(px(8'h11, 8'h22, 8'h33, 8'h00), px(8'h99, 8'h88, 8'h77, 8'h66));
        send_pixel(px(8'h11, 8'h22, 8'h33, 8'h01), px(8'h99, 8'h88, 8'h77, 8'h66));
        write_reg(REG_THRESH, 32'd127);
        send_pixel(px(8'hff, 8'h00, 8'hff, 8'h7f), px(8'h00, 8'hff, 8'h00, 8'hff));
        send_pixel(px(8'hff, 8'h00, 8'hff, 8'h80), px(8'h00, 8'hff, 8'h00, 8'hff));
        write_reg(REG_THRESH, 32'd255);
        send_pixel(px(8'hff, 8'hff, 8'hff, 8'hff), px(8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_alpha_blend();
        drain_pipeline();
        write_reg(REG_MODE, 32'(MODE_BLEND));
        // scale still at full weight from reset
        send_pixel(px(8'hff, 8'h00, 8'h80, 8'hff), px(8'h00, 8'hff, 8'h7f, 8'h00));
        send_pixel(px(8'hff, 8'h00, 8'h80, 8'h00), px(8'h00, 8'hff, 8'h7f, 8'h40));
        send_pixel(px(8'h03, 8'hfd, 8'h01, 8'h80), px(8'hfe, 8'h02, 8'h00, 8'hc0));
        write_reg(REG_SCALE, 32'd300);
        send_pixel(px(8'h00, 8'hff, 8'h40, 8'hc0), px(8'hff, 8'h00, 8'hc0, 8'h10));
        write_reg(REG_SCALE, 32'd0);
        send_pixel(px(8'hff, 8'hff, 8'hff, 8'hff), px(8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_const_alpha();
        drain_pipeline();
        write_reg(REG_MODE, 32'(MODE_CONST));
        write_reg(REG_SCALE, 32'd128);
        send_pixel(px(8'h00, 8'hff, 8'h01, 8'h10), px(8'hff, 8'h00, 8'h00, 8'h11));
        write_reg(REG_SCALE, 32'(SCALE_ONE));
        send_pixel(px(8'h12, 8'h34, 8'h56, 8'h78), px(8'hfe, 8'hdc, 8'hba, 8'h98));
        write_reg(REG_SCALE, 32'd511);
        send_pixel(px(8'h00, 8'hff, 8'h00, 8'hff), px(8'hff, 8'h00, 8'hff, 8'h00));
        write_reg(REG_SCALE, 32'd1);
        send_pixel(px(8'h00, 8'hff, 8'h00, 8'hff), px(8'hff, 8'h00, 8'hff, 8'h00));
    endtask

    // modes past constant alpha leave the destination untouched
    task automatic test_undefined_mode();
        logic [2:0] m;
        for (m = MODE_CONST + 3'd1; m != 3'd0; m++)
        begin
            drain_pipeline();
            write_reg(REG_MODE, 32'(m));
            send_pixel(rand_pixel(), rand_pixel());
        end
    endtask

    task automatic test_random(input int n_segments, input int seg_len);
        logic [2:0]  mode_sel;
        logic [31:0] scale_sel;
        rgba_t       src;
        rgba_t       dst;
        int          pick;
        for (int seg = 0; seg < n_segments; seg++)
        begin
            drain_pipeline();
            pick = $urandom_range(15);
            if (pick < 13)
                mode_sel = 3'(pick % 5);
            else
                mode_sel = 3'($urandom_range(MODE_TOP, MODE_CONST + 1));
            case ($urandom_range(7))
                0:       scale_sel = 32'd0;
                1:       scale_sel = 32'(SCALE_ONE);
                2:       scale_sel = $urandom_range(511, SCALE_ONE + 1);
                default: scale_sel = $urandom_range(SCALE_ONE);
            endcase
            write_reg(REG_MODE, 32'(mode_sel));
            write_reg(REG_KEY, $urandom);
            case ($urandom_range(3))
                0:       write_reg(REG_THRESH, 32'd0);
                1:       write_reg(REG_THRESH, 32'd255);
                default: write_reg(REG_THRESH, $urandom_range(255));
            endcase
            write_reg(REG_SCALE, scale_sel);
            for (int i = 0; i < seg_len; i++)
            begin
                src = rand_pixel();
                dst = rand_pixel();
                pick = $urandom_range(3);
                // steer toward the key and the threshold edge often enough to hit them
                if (shadow_mode == MODE_KEY && pick == 0)
                    src = shadow_key;
                else if (shadow_mode == MODE_KEY && pick == 1)
                    src = shadow_key ^ (32'd1 << $urandom_range(31));
                else if (shadow_mode == MODE_TEST && pick == 0)
                    src.alpha = shadow_thresh + chan_t'($urandom_range(1));
                send_pixel(src, dst);
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct  = 27;
        sink_idle_pct = 69;
        test_copy();
        test_color_key();
        test_alpha_test();
        test_alpha_blend();
        test_const_alpha();
        test_undefined_mode();
        test_random(10, 35);

        src_idle_pct  = 69;
        sink_idle_pct = 27;
        test_random(10, 35);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random(10, 35);

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** pixel_compositing_unit_top: PASSED **");
        else
            $display("** pixel_compositing_unit_top: FAILED **");
        $finish;
    end

endmodule

@@ pixel_compositing_unit_top.f @@
+incdir+sv
sv/pcu_pkg.sv
sv/pcu_lane.sv
sv/pcu_merge.sv
sv/pixel_compositing_unit_top.sv
sv/pcu_checker.sv
sim/tb_pixel_compositing_unit_top.sv
